// ----- src/sld_pkg.sv -----
`timescale 1ns / 1ps

package sld_pkg;

    localparam logic [7:0] SYNC0 = 8'hFF;
    localparam logic [7:0] SYNC1 = 8'hA5;
    localparam logic [7:0] SYNC2 = 8'h5A;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd200;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_BADSUM  = 2'd2;
    localparam logic [1:0] ST_LENERR  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_GOT_FF  = 3'd1,
        PH_GOT_A5  = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       frame_end;
    } result_t;

endpackage

// ----- src/sync_length_xor_frame_decoder.sv -----
`timescale 1ns / 1ps

// Deframer for a byte stream: hunts for the sync FF A5 5A (overlapping match),
// reads a length byte L, passes the L-1 payload bytes on as status 0 results
// and closes the frame with status 1 (checksum ok), 2 (mismatch) or 3 (L zero
// or above max_length). The checksum is L XOR-ed with every payload byte.
// One byte is taken per cycle while the output buffer is not full. A result
// passes from the input register through the decode into a two-entry output
// buffer before it shows on the m_ ports. The phase/XOR update sets the rate.
// Write max_length only while the block is idle.
module sync_length_xor_frame_decoder
    import sld_pkg::*;
#(
    parameter logic [7:0] MAX_LEN_RESET = MAX_LENGTH_RESET
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [1:0] m_status,
    output logic       m_frame_end
);

    logic [7:0] max_length_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       buf_full;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    m_data;

    assign step    = in_valid_reg && !buf_full;
    assign s_ready = !in_valid_reg || !buf_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    sld_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    sld_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (buf_full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_payload_byte = m_data.payload_byte;
    assign m_status       = m_data.status;
    assign m_frame_end    = m_data.frame_end;

endmodule

// ----- src/sld_decode.sv -----
`timescale 1ns / 1ps

module sld_decode
    import sld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic [7:0] max_length,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic       len_bad;
    logic [7:0] left_dec;

    assign len_bad  = (rx_byte == 8'd0) || (rx_byte > max_length);
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        running_xor_next = running_xor_reg;
        case (phase_reg)
            PH_GOT_FF: begin
                if (rx_byte == SYNC1) begin
                    phase_next = PH_GOT_A5;
                end else if (rx_byte == SYNC0) begin
                    phase_next = PH_GOT_FF;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_GOT_A5: begin
                if (rx_byte == SYNC2) begin
                    phase_next = PH_LEN;
                end else if (rx_byte == SYNC0) begin
                    phase_next = PH_GOT_FF;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN: begin
                if (len_bad) begin
                    phase_next       = PH_HUNT;
                    bytes_left_next  = 8'd0;
                    running_xor_next = 8'd0;
                end else begin
                    running_xor_next = rx_byte;
                    bytes_left_next  = rx_byte - 8'd1;
                    phase_next       = (rx_byte == 8'd1) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                running_xor_next = running_xor_reg ^ rx_byte;
                bytes_left_next  = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                phase_next       = PH_HUNT;
                bytes_left_next  = 8'd0;
                running_xor_next = 8'd0;
            end
            default: begin
                phase_next = (rx_byte == SYNC0) ? PH_GOT_FF : PH_HUNT;
            end
        endcase
    end

    always_comb begin
        res_valid        = 1'b0;
        res.payload_byte = 8'd0;
        res.status       = ST_PAYLOAD;
        res.frame_end    = 1'b0;
        case (phase_reg)
            PH_LEN: begin
                if (len_bad) begin
                    res_valid     = step;
                    res.status    = ST_LENERR;
                    res.frame_end = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                res_valid        = step;
                res.payload_byte = rx_byte;
            end
            PH_CHECK: begin
                res_valid     = step;
                res.status    = (rx_byte == running_xor_reg) ? ST_OK : ST_BADSUM;
                res.frame_end = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            bytes_left_reg  <= 8'd0;
            running_xor_reg <= 8'd0;
        end else if (step) begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            running_xor_reg <= running_xor_next;
        end
    end

endmodule

// ----- src/sld_out_buf.sv -----
`timescale 1ns / 1ps

module sld_out_buf
    import sld_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    full,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign rd_en   = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- verif/sync_length_xor_frame_decoder_tb.sv -----
`timescale 1ns / 1ps

module sync_length_xor_frame_decoder_tb;
    import sld_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_BYTES   = 236;

    typedef enum logic [1:0] {
        RQ_BYTE,
        RQ_SET_MAX,
        RQ_DRAIN
    } rq_kind_t;

    typedef struct {
        rq_kind_t   kind;
        logic [7:0] value;
    } rx_req_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_payload_byte;
    logic [1:0] m_status;
    logic       m_frame_end;

    rx_req_t    rx_pending[$];
    result_t    frame_exp_q[$];
    result_t    want;

    // deframer mirror
    phase_t     frm_phase;
    logic [7:0] frm_left;
    logic [7:0] frm_xor;
    logic [7:0] len_limit;

    logic       drained = 1'b1;
    int         settle_cnt = 0;
    int         mismatch_cnt = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         framed_bytes = 0;
    rx_mode_t   rx_mode = RX_OPEN;
    int         rx_span = 0;

    sync_length_xor_frame_decoder DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_status       (m_status),
        .m_frame_end    (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        case (frm_phase)
            PH_GOT_FF: begin
                if (b == SYNC1) frm_phase = PH_GOT_A5;
                else if (b == SYNC0) frm_phase = PH_GOT_FF;
                else frm_phase = PH_HUNT;
            end
            PH_GOT_A5: begin
                if (b == SYNC2) frm_phase = PH_LEN;
                else if (b == SYNC0) frm_phase = PH_GOT_FF;
                else frm_phase = PH_HUNT;
            end
            PH_LEN: begin
                if (b == 8'd0 || b > len_limit) begin
                    frm_phase = PH_HUNT;
                    frm_left = 8'd0;
                    frm_xor = 8'd0;
                    r.status = ST_LENERR;
                    r.frame_end = 1'b1;
                    frame_exp_q.push_back(r);
                end else begin
                    frm_xor = b;
                    frm_left = b - 8'd1;
                    if (frm_left == 8'd0) frm_phase = PH_CHECK;
                    else frm_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                frm_xor = frm_xor ^ b;
                frm_left = frm_left - 8'd1;
                if (frm_left == 8'd0) frm_phase = PH_CHECK;
                r.payload_byte = b;
                r.status = ST_PAYLOAD;
                frame_exp_q.push_back(r);
            end
            PH_CHECK: begin
                r.status = (b == frm_xor) ? ST_OK : ST_BADSUM;
                r.frame_end = 1'b1;
                frm_phase = PH_HUNT;
                frm_left = 8'd0;
                frm_xor = 8'd0;
                frame_exp_q.push_back(r);
            end
            default: begin
                if (b == SYNC0) frm_phase = PH_GOT_FF;
                else frm_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] v);
        rx_req_t q;
        q.kind = RQ_BYTE;
        q.value = v;
        rx_pending.push_back(q);
    endtask

    task automatic push_ctrl(input rq_kind_t k, input logic [7:0] v);
        rx_req_t q;
        q.kind = k;
        q.value = v;
        rx_pending.push_back(q);
    endtask

    task automatic push_frame(input int cap);
        int         pick;
        int         len;
        logic [7:0] b;
        logic [7:0] sum;
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 0;
        else if (pick == 1) len = (cap >= 255) ? 0 : $urandom_range(255, cap + 1);
        else if (cap == 0) len = $urandom_range(1, 8);
        else if (pick == 2 && (cap <= 16 || $urandom_range(0, 3) == 0)) len = cap;
        else if (pick == 3) len = $urandom_range(1, (cap < 24) ? cap : 24);
        else len = $urandom_range(1, (cap < 8) ? cap : 8);
        push_byte(SYNC0);
        push_byte(SYNC1);
        push_byte(SYNC2);
        push_byte(len[7:0]);
        framed_bytes += 4;
        if (len == 0 || len > cap) return;
        sum = len[7:0];
        for (int i = 1; i < len; i++) begin
            b = $urandom_range(0, 255);
            sum = sum ^ b;
            push_byte(b);
        end
        if ($urandom_range(0, 3) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
        framed_bytes += len;
    endtask

    task automatic push_noise();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            push_byte(SYNC0);
            push_byte(SYNC1);
            push_byte(8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
            push_byte(SYNC0);
            push_byte(SYNC0);
        end else if (pick == 2) begin
            push_byte(SYNC0);
            push_byte(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial begin
        logic [7:0] caps[6];
        caps = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 254)), 8'd200, 8'd128};

        // repeated FF, length one, good checksum
        push_byte(SYNC0); push_byte(SYNC0); push_byte(SYNC1); push_byte(SYNC2);
        push_byte(8'd1); push_byte(8'd1);
        // FF after FF A5 restarts the match, then zero length
        push_byte(SYNC0); push_byte(SYNC1); push_byte(SYNC0); push_byte(SYNC1);
        push_byte(SYNC2); push_byte(8'd0);
        // length just above the reset limit
        push_byte(SYNC0); push_byte(SYNC1); push_byte(SYNC2); push_byte(8'd201);
        // payload extremes, bad checksum
        push_byte(SYNC0); push_byte(SYNC1); push_byte(SYNC2); push_byte(8'd3);
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00);

        for (int p = 0; p < 6; p++) begin
            push_ctrl(RQ_SET_MAX, caps[p]);
            framed_bytes = 0;
            while (framed_bytes < PHASE_BYTES) begin
                push_noise();
                push_frame(caps[p]);
                if (p % 2 == 1 && framed_bytes >= PHASE_BYTES / 2
                        && framed_bytes < PHASE_BYTES / 2 + 12)
                    push_ctrl(RQ_DRAIN, 8'd0);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_pending.size() != 0 || s_valid) @(negedge aclk);
        while (!drained) @(negedge aclk);
        repeat (SETTLE_CYCLES * 2) @(negedge aclk);
        if (mismatch_cnt == 0 && drained) begin
            $display("sync_length_xor_frame_decoder_tb passed");
        end else begin
            $display("sync_length_xor_frame_decoder_tb failed");
        end
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_rx_byte <= 8'd0;
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= 8'd0;
            burst_left = $urandom_range(1, 16);
            gap_left = 0;
        end else begin
            cfg_wr_en <= 1'b0;
            if (!s_valid || s_ready) begin
                if (gap_left != 0 || rx_pending.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    case (rx_pending[0].kind)
                        RQ_BYTE: begin
                            s_valid <= 1'b1;
                            s_rx_byte <= rx_pending[0].value;
                            void'(rx_pending.pop_front());
                            if (burst_left <= 1) begin
                                burst_left = ($urandom_range(0, 9) == 0) ?
                                             300 : $urandom_range(1, 16);
                                gap_left = ($urandom_range(0, 3) == 0) ?
                                           0 : $urandom_range(1, 10);
                            end else begin
                                burst_left--;
                            end
                        end
                        RQ_SET_MAX: begin
                            s_valid <= 1'b0;
                            if (!s_valid && drained && settle_cnt >= SETTLE_CYCLES) begin
                                cfg_wr_en <= 1'b1;
                                cfg_wr_data <= rx_pending[0].value;
                                void'(rx_pending.pop_front());
                            end
                        end
                        default: begin
                            s_valid <= 1'b0;
                            if (!s_valid && drained) void'(rx_pending.pop_front());
                        end
                    endcase
                end
            end
        end
    end

    // result monitor and prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            frm_phase = PH_HUNT;
            frm_left = 8'd0;
            frm_xor = 8'd0;
            len_limit = MAX_LENGTH_RESET;
            frame_exp_q.delete();
            drained <= 1'b1;
            settle_cnt <= 0;
        end else begin
            if (cfg_wr_en) len_limit = cfg_wr_data;
            if (s_valid && s_ready) deframe_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (frame_exp_q.size() == 0) begin
                    $error("unexpected result: payload_byte %0h status %0d frame_end %0b",
                           m_payload_byte, m_status, m_frame_end);
                    mismatch_cnt++;
                end else begin
                    want = frame_exp_q.pop_front();
                    if (m_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, m_payload_byte);
                        mismatch_cnt++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatch_cnt++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, m_frame_end);
                        mismatch_cnt++;
                    end
                end
            end
            drained <= (frame_exp_q.size() == 0);
            if ((s_valid && s_ready) || frame_exp_q.size() != 0) settle_cnt <= 0;
            else if (settle_cnt < SETTLE_CYCLES) settle_cnt <= settle_cnt + 1;
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode = RX_OPEN;
            rx_span = 0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_span = $urandom_range(4, 60);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ((rx_span % 8) < 5);
            endcase
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sync_length_xor_frame_decoder_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
